// File: rtl/ihex_pkg.sv
// Shared types, constants and helpers for the Intel HEX record encoder.
`default_nettype none

package ihex_pkg;

   // Characters
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // Record type of data records
   localparam logic [7:0] DATA_REC_TYPE = 8'h00;

   // Configuration register indexes and reset values
   localparam int          CSR_IDX_W         = 2;
   localparam int          CSR_DATA_W        = 16;
   localparam logic [1:0]  CSR_RECORD_LENGTH = 2'd0;
   localparam logic [1:0]  CSR_TOTAL_LENGTH  = 2'd1;
   localparam logic [1:0]  CSR_START_ADDRESS = 2'd2;
   localparam logic [7:0]  RECORD_LENGTH_RST = 8'd16;
   localparam logic [15:0] TOTAL_LENGTH_RST  = 16'd1;

   // End-of-file record text, line feed excluded
   localparam int EOF_TEXT_LEN = 11;
   localparam int EOF_IDX_W    = $clog2(EOF_TEXT_LEN);
   localparam logic [7:0] EOF_TEXT [EOF_TEXT_LEN] = '{
      8'h3A, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h31, 8'h46, 8'h46
   };

   // One classified byte: everything the character sequencer needs
   typedef struct packed {
      logic [7:0]  data;
      logic        open_rec;
      logic [7:0]  count;
      logic [15:0] addr;
      logic        close_rec;
      logic [7:0]  checksum;
      logic        close_xfer;
   } cmd_type;

   // Character positions within the output text of one byte
   typedef enum logic [3:0] {
      S_COLON,
      S_CNT_HI,
      S_CNT_LO,
      S_ADR3,
      S_ADR2,
      S_ADR1,
      S_ADR0,
      S_TYP_HI,
      S_TYP_LO,
      S_DAT_HI,
      S_DAT_LO,
      S_CKS_HI,
      S_CKS_LO,
      S_EOL,
      S_EOF_TXT,
      S_EOF_EOL
   } step_type;

   // Uppercase ASCII hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] base;
      base = (nib < 4'd10) ? 8'h30 : 8'h37;
      return base + {4'h0, nib};
   endfunction

endpackage

`default_nettype wire

// File: rtl/ihex_if.sv
// Channel interfaces: byte requests, character results, register writes.
`default_nettype none

interface ihex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ihex_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] ascii_char;
   logic       end_of_line;
   logic       last;

   modport source (output valid, output ascii_char, output end_of_line, output last,
                   input ready);
   modport sink   (input valid, input ascii_char, input end_of_line, input last,
                   output ready);
endinterface

interface ihex_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ihex_pkg::CSR_IDX_W-1:0]  index;
   logic [ihex_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/ihex_front.sv
// Front end: registers, transfer/record bookkeeping, classification of each byte.
`default_nettype none

module ihex_front (
   input  wire logic          clock,
   input  wire logic          reset,
   ihex_req_if.sink           req,
   ihex_csr_if.sink           csr,
   output ihex_pkg::cmd_type  push_cmd,
   output logic               push_valid,
   input  wire logic          push_ready
);

   logic [7:0]  record_length_ff, record_length_in;
   logic [15:0] total_length_ff, total_length_in;
   logic [15:0] address_ff, address_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [7:0]  record_left_ff, record_left_in;
   logic [7:0]  sum_ff, sum_in;

   logic        accept;
   logic        xfer_open;
   logic [15:0] br;
   logic [7:0]  rl;
   logic        open_rec;
   logic [7:0]  limit;
   logic [7:0]  count;
   logic [7:0]  sum0;
   logic [7:0]  sum1;
   logic [7:0]  rl1;
   logic [15:0] br1;
   logic        close_rec;
   logic        close_xfer;

   assign csr.ready  = 1'b1;
   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign accept     = req.valid && push_ready;

   always_comb begin
      xfer_open = (remaining_ff != 16'd0);
      br        = xfer_open ? remaining_ff
                            : ((total_length_ff == 16'd0) ? 16'd1 : total_length_ff);
      rl        = xfer_open ? record_left_ff : 8'd0;
      open_rec  = (rl == 8'd0);
      limit     = (record_length_ff == 8'd0) ? 8'd1 : record_length_ff;
      count     = (br < {8'h00, limit}) ? br[7:0] : limit;
      sum0      = open_rec ? (count + address_ff[7:0] + address_ff[15:8]) : sum_ff;
      sum1      = sum0 + req.data_byte;
      rl1       = (open_rec ? count : rl) - 8'd1;
      br1       = br - 16'd1;
      close_rec  = (rl1 == 8'd0);
      close_xfer = (br1 == 16'd0);
   end

   always_comb begin
      push_cmd.data       = req.data_byte;
      push_cmd.open_rec   = open_rec;
      push_cmd.count      = count;
      push_cmd.addr       = address_ff;
      push_cmd.close_rec  = close_rec;
      push_cmd.checksum   = 8'h00 - sum1;
      push_cmd.close_xfer = close_xfer;
   end

   always_comb begin
      record_length_in = record_length_ff;
      total_length_in  = total_length_ff;
      address_in       = address_ff;
      remaining_in     = remaining_ff;
      record_left_in   = record_left_ff;
      sum_in           = sum_ff;
      if (accept) begin
         if (open_rec) begin
            address_in = address_ff + {8'h00, count};
         end
         sum_in         = close_rec ? 8'h00 : sum1;
         record_left_in = close_xfer ? 8'd0 : rl1;
         remaining_in   = br1;
      end
      // Writes are to arrive only while idle; the block itself does not enforce this
      if (csr.valid) begin
         unique case (csr.index)
            ihex_pkg::CSR_RECORD_LENGTH: record_length_in = csr.data[7:0];
            ihex_pkg::CSR_TOTAL_LENGTH:  total_length_in  = csr.data;
            ihex_pkg::CSR_START_ADDRESS: address_in       = csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         record_length_ff <= ihex_pkg::RECORD_LENGTH_RST;
         total_length_ff  <= ihex_pkg::TOTAL_LENGTH_RST;
         address_ff       <= 16'd0;
         remaining_ff     <= 16'd0;
         record_left_ff   <= 8'd0;
         sum_ff           <= 8'd0;
      end else begin
         record_length_ff <= record_length_in;
         total_length_ff  <= total_length_in;
         address_ff       <= address_in;
         remaining_ff     <= remaining_in;
         record_left_ff   <= record_left_in;
         sum_ff           <= sum_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ihex_queue.sv
// Small FIFO of classified bytes between front end and character sequencer.
`default_nettype none

module ihex_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire ihex_pkg::cmd_type push_cmd,
   output logic                   push_ready,
   output logic                   pop_valid,
   output ihex_pkg::cmd_type      pop_cmd,
   input  wire logic              pop_ready
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ihex_pkg::cmd_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (fill_ff != CNT_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_cmd    = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ihex_back.sv
// Back end: walks the characters of one classified byte into the output register.
`default_nettype none

module ihex_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   input  wire ihex_pkg::cmd_type pop_cmd,
   output logic                   pop_ready,
   ihex_rsp_if.source             rsp
);

   ihex_pkg::step_type step_ff, step_in;
   ihex_pkg::step_type cur_step;
   ihex_pkg::step_type nxt_step;
   logic                            mid_ff, mid_in;
   logic [ihex_pkg::EOF_IDX_W-1:0]  eof_idx_ff, eof_idx_in;
   logic [ihex_pkg::EOF_IDX_W-1:0]  eof_nxt;
   logic                            done;
   logic                            out_free;
   logic                            fire;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] char_ff, char_in;
   logic       eol_ff, eol_in;
   logic       last_ff, last_in;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign fire      = pop_valid && out_free;
   assign pop_ready = fire && done;

   // Start of a new entry: header only when it opens a record
   assign cur_step = mid_ff ? step_ff
                            : (pop_cmd.open_rec ? ihex_pkg::S_COLON : ihex_pkg::S_DAT_HI);

   // Next position
   always_comb begin
      nxt_step = cur_step;
      eof_nxt  = '0;
      done     = 1'b0;
      unique case (cur_step)
         ihex_pkg::S_COLON:  nxt_step = ihex_pkg::S_CNT_HI;
         ihex_pkg::S_CNT_HI: nxt_step = ihex_pkg::S_CNT_LO;
         ihex_pkg::S_CNT_LO: nxt_step = ihex_pkg::S_ADR3;
         ihex_pkg::S_ADR3:   nxt_step = ihex_pkg::S_ADR2;
         ihex_pkg::S_ADR2:   nxt_step = ihex_pkg::S_ADR1;
         ihex_pkg::S_ADR1:   nxt_step = ihex_pkg::S_ADR0;
         ihex_pkg::S_ADR0:   nxt_step = ihex_pkg::S_TYP_HI;
         ihex_pkg::S_TYP_HI: nxt_step = ihex_pkg::S_TYP_LO;
         ihex_pkg::S_TYP_LO: nxt_step = ihex_pkg::S_DAT_HI;
         ihex_pkg::S_DAT_HI: nxt_step = ihex_pkg::S_DAT_LO;
         ihex_pkg::S_DAT_LO: begin
            priority if (pop_cmd.close_rec) begin
               nxt_step = ihex_pkg::S_CKS_HI;
            end else if (pop_cmd.close_xfer) begin
               nxt_step = ihex_pkg::S_EOF_TXT;
            end else begin
               done = 1'b1;
            end
         end
         ihex_pkg::S_CKS_HI: nxt_step = ihex_pkg::S_CKS_LO;
         ihex_pkg::S_CKS_LO: nxt_step = ihex_pkg::S_EOL;
         ihex_pkg::S_EOL: begin
            if (pop_cmd.close_xfer) begin
               nxt_step = ihex_pkg::S_EOF_TXT;
            end else begin
               done = 1'b1;
            end
         end
         ihex_pkg::S_EOF_TXT: begin
            if (eof_idx_ff == ihex_pkg::EOF_IDX_W'(ihex_pkg::EOF_TEXT_LEN - 1)) begin
               nxt_step = ihex_pkg::S_EOF_EOL;
            end else begin
               eof_nxt = eof_idx_ff + 1'b1;
            end
         end
         ihex_pkg::S_EOF_EOL: done = 1'b1;
         default:             done = 1'b1;
      endcase
   end

   // Character at the current position
   always_comb begin
      char_in = ihex_pkg::CHAR_COLON;
      eol_in  = 1'b0;
      last_in = 1'b0;
      unique case (cur_step)
         ihex_pkg::S_COLON:   char_in = ihex_pkg::CHAR_COLON;
         ihex_pkg::S_CNT_HI:  char_in = ihex_pkg::hex_char(pop_cmd.count[7:4]);
         ihex_pkg::S_CNT_LO:  char_in = ihex_pkg::hex_char(pop_cmd.count[3:0]);
         ihex_pkg::S_ADR3:    char_in = ihex_pkg::hex_char(pop_cmd.addr[15:12]);
         ihex_pkg::S_ADR2:    char_in = ihex_pkg::hex_char(pop_cmd.addr[11:8]);
         ihex_pkg::S_ADR1:    char_in = ihex_pkg::hex_char(pop_cmd.addr[7:4]);
         ihex_pkg::S_ADR0:    char_in = ihex_pkg::hex_char(pop_cmd.addr[3:0]);
         ihex_pkg::S_TYP_HI:  char_in = ihex_pkg::hex_char(ihex_pkg::DATA_REC_TYPE[7:4]);
         ihex_pkg::S_TYP_LO:  char_in = ihex_pkg::hex_char(ihex_pkg::DATA_REC_TYPE[3:0]);
         ihex_pkg::S_DAT_HI:  char_in = ihex_pkg::hex_char(pop_cmd.data[7:4]);
         ihex_pkg::S_DAT_LO:  char_in = ihex_pkg::hex_char(pop_cmd.data[3:0]);
         ihex_pkg::S_CKS_HI:  char_in = ihex_pkg::hex_char(pop_cmd.checksum[7:4]);
         ihex_pkg::S_CKS_LO:  char_in = ihex_pkg::hex_char(pop_cmd.checksum[3:0]);
         ihex_pkg::S_EOL: begin
            char_in = ihex_pkg::CHAR_LF;
            eol_in  = 1'b1;
         end
         ihex_pkg::S_EOF_TXT: char_in = ihex_pkg::EOF_TEXT[eof_idx_ff];
         ihex_pkg::S_EOF_EOL: begin
            char_in = ihex_pkg::CHAR_LF;
            eol_in  = 1'b1;
            last_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      mid_in       = mid_ff;
      eof_idx_in   = eof_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         step_in      = nxt_step;
         mid_in       = !done;
         eof_idx_in   = eof_nxt;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ihex_pkg::S_COLON;
         mid_ff       <= 1'b0;
         eof_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         mid_ff       <= mid_in;
         eof_idx_ff   <= eof_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         char_ff <= char_in;
         eol_ff  <= eol_in;
         last_ff <= last_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.ascii_char  = char_ff;
   assign rsp.end_of_line = eol_ff;
   assign rsp.last        = last_ff;

endmodule

`default_nettype wire

// File: rtl/intel_hex_record_encoder.sv
// Intel HEX record encoder: data bytes in, Intel HEX text out one character at a time.
`default_nettype none

// Each request carries one data byte of a transfer; the response channel
// delivers the resulting Intel HEX text, one ASCII character per response.
// A byte arriving with no transfer open starts one of total_length bytes
// (0 counts as 1). Records hold up to record_length bytes (0 counts as 1),
// the address advances by the record count and wraps at 16 bits, and the
// end-of-file record ":00000001FF" plus a line feed closes every transfer.
// end_of_line marks each record's line feed, last marks the final one.
// Rate: the output emits one character per cycle while the receiver takes
// them; a byte gives 2 characters mid-record, 9 more when it opens a record,
// 3 more when it closes one and 12 more when it ends the transfer, about
// 2.75 characters per byte with 16-byte records; the sequencer sets the rate.
// The front end classifies a byte in the cycle it is accepted and runs up
// to QUEUE_DEPTH bytes ahead of the sequencer, so requests keep flowing
// while earlier characters are still waiting to be taken. Registers are
// written through the csr channel (always ready) and should be written
// only while no characters are pending; writing start_address sets the
// address of the next record.

module intel_hex_record_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   ihex_req_if.sink     req_ch,
   ihex_rsp_if.source   rsp_ch,
   ihex_csr_if.sink     csr_ch
);

   // Front end to queue
   ihex_pkg::cmd_type push_cmd;
   logic              push_valid;
   logic              push_ready;

   // Queue to sequencer
   ihex_pkg::cmd_type pop_cmd;
   logic              pop_valid;
   logic              pop_ready;

   ihex_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .csr        (csr_ch),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   ihex_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   ihex_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop_ready (pop_ready),
      .rsp       (rsp_ch)
   );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the Intel HEX record encoder: random byte transfers vs. a text predictor.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Index with no register behind it; writes to it must be dropped.
   localparam logic [ihex_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int RESET_CYCLES  = 10;
   localparam int DRAIN_CYCLES  = 40;      // trailing quiet time after the last character
   localparam int MAX_REPORTS   = 20;      // cap on printed mismatches
   localparam int PHASE_ITEMS   = 20;      // least number of random requests per idling phase
   localparam int WIDE_XFER_LEN = 24;      // bytes sent into the 65535-byte transfer

   // One expected output character with its flags.
   typedef struct packed {
      logic [7:0] ascii_char;
      logic       end_of_line;
      logic       last;
   } expected_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ihex_req_if req_ch ();
   ihex_rsp_if rsp_ch ();
   ihex_csr_if csr_ch ();

   intel_hex_record_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Text predictor: mirrors the encoder's registers and record state.
   // ------------------------------------------------------------------
   logic [7:0]  cfg_rec_len  = ihex_pkg::RECORD_LENGTH_RST;
   logic [15:0] cfg_xfer_len = ihex_pkg::TOTAL_LENGTH_RST;
   logic [15:0] load_addr    = '0;   // address of the next record to open
   logic [15:0] xfer_left    = '0;   // zero: no transfer open
   logic [7:0]  rec_left     = '0;   // zero: no record open
   logic [7:0]  rec_count    = '0;
   logic [7:0]  rec_sum      = '0;   // count + address bytes + data, mod 256

   expected_char_type hex_text_q[$]; // characters still owed by the encoder
   logic [7:0] data_byte_q[$];       // requests not yet handed to the driver

   int bytes_queued     = 0;
   int bytes_accepted   = 0;
   int chars_checked    = 0;
   int records_closed   = 0;
   int transfers_closed = 0;
   int fail_count       = 0;

   int send_idle_pct = 0;            // chance per cycle that the sender holds off
   int rsp_stall_pct = 0;            // chance per cycle that the receiver stalls
   logic req_taken   = 1'b0;         // request accepted at the last rising edge

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return 8'h30 + 8'(nib);
      end
      return 8'h41 + 8'(nib - 4'd10);
   endfunction

   task automatic emit(input logic [7:0] ch, input logic eol, input logic fin);
      hex_text_q.push_back('{ascii_char: ch, end_of_line: eol, last: fin});
   endtask

   task automatic emit_hex(input logic [7:0] v);
      emit(hex_digit(v[7:4]), 1'b0, 1'b0);
      emit(hex_digit(v[3:0]), 1'b0, 1'b0);
   endtask

   task automatic apply_csr(input logic [ihex_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ihex_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         ihex_pkg::CSR_RECORD_LENGTH: cfg_rec_len = value[7:0];
         ihex_pkg::CSR_TOTAL_LENGTH:  cfg_xfer_len = value;
         ihex_pkg::CSR_START_ADDRESS: load_addr = value;   // next record opens here
         default: ;                                        // unknown index: dropped
      endcase
   endtask

   // Characters one accepted data byte gives rise to.
   task automatic encode_byte(input logic [7:0] data);
      logic [7:0] limit;
      logic [7:0] cnt;
      // first byte with no transfer open samples total_length (0 counts as 1)
      if (xfer_left == 16'd0) begin
         xfer_left = (cfg_xfer_len == 16'd0) ? 16'd1 : cfg_xfer_len;
         rec_left  = 8'd0;
      end
      // record header: ':' count address type
      if (rec_left == 8'd0) begin
         limit     = (cfg_rec_len == 8'd0) ? 8'd1 : cfg_rec_len;
         cnt       = (xfer_left < 16'(limit)) ? xfer_left[7:0] : limit;
         rec_count = cnt;
         rec_left  = cnt;
         rec_sum   = cnt + load_addr[7:0] + load_addr[15:8];
         emit(ihex_pkg::CHAR_COLON, 1'b0, 1'b0);
         emit_hex(cnt);
         emit_hex(load_addr[15:8]);
         emit_hex(load_addr[7:0]);
         emit_hex(ihex_pkg::DATA_REC_TYPE);
         load_addr = load_addr + 16'(cnt);        // wraps at 64K
      end
      emit_hex(data);
      rec_sum   = rec_sum + data;
      rec_left  = rec_left - 8'd1;
      xfer_left = xfer_left - 16'd1;
      // record trailer: two's-complement checksum, line feed
      if (rec_left == 8'd0) begin
         emit_hex(8'h00 - rec_sum);
         emit(ihex_pkg::CHAR_LF, 1'b1, 1'b0);
         rec_sum = 8'd0;
      end
      // end-of-file record ":00000001FF"
      if (xfer_left == 16'd0) begin
         emit(ihex_pkg::CHAR_COLON, 1'b0, 1'b0);
         emit_hex(8'h00);
         emit_hex(8'h00);
         emit_hex(8'h00);
         emit_hex(8'h01);
         emit_hex(8'hFF);
         emit(ihex_pkg::CHAR_LF, 1'b1, 1'b1);
         rec_left  = 8'd0;
         rec_count = 8'd0;
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: inputs change on the falling edge only.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : byte_driver
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         // hold a request until taken, then offer the next or idle
         if (!req_ch.valid || req_taken) begin
            if (data_byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid     <= 1'b1;
               req_ch.data_byte <= data_byte_q.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: samples every channel on the rising edge. Register writes
   // and requests feed the predictor before any character is compared.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : char_monitor
      expected_char_type want;
      req_taken <= !reset && req_ch.valid === 1'b1 && req_ch.ready === 1'b1;
      if (!reset) begin
         if (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1) begin
            apply_csr(csr_ch.index, csr_ch.data);
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            encode_byte(req_ch.data_byte);
            bytes_accepted++;
         end
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            chars_checked++;
            if (rsp_ch.end_of_line === 1'b1) records_closed++;
            if (rsp_ch.last === 1'b1) transfers_closed++;
            if (hex_text_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("%0t: unexpected character, expected none, got %h eol=%b last=%b",
                           $time, rsp_ch.ascii_char, rsp_ch.end_of_line, rsp_ch.last);
               end
            end else begin
               want = hex_text_q.pop_front();
               check_field("ascii_char", want.ascii_char, rsp_ch.ascii_char);
               check_field("end_of_line", 8'(want.end_of_line), 8'(rsp_ch.end_of_line));
               check_field("last", 8'(want.last), 8'(rsp_ch.last));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] b);
      data_byte_q.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_random_bytes(input int n);
      repeat (n) queue_byte(8'($urandom_range(255)));
   endtask

   // Every request taken and every character delivered. The sender has
   // nothing to offer meanwhile, so this is also the full-drain pause.
   task automatic wait_idle();
      do @(negedge clock);
      while (bytes_accepted != bytes_queued || hex_text_q.size() != 0);
   endtask

   task automatic csr_write(input logic [ihex_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ihex_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock);
      while (csr_ch.ready !== 1'b1);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int phase;
      int phase_items;
      int n;
      logic [7:0]  rl;
      logic [15:0] tl;

      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'h00;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = '0;
      csr_ch.data      = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // first idling mix: sender 10 %, receiver 80 %
      send_idle_pct = 10;
      rsp_stall_pct = 80;

      // --- directed part ---
      // reset defaults: 16-byte records, single-byte transfer at 0000
      queue_byte(8'h00);
      wait_idle();

      // zero lengths count as one
      csr_write(ihex_pkg::CSR_RECORD_LENGTH, 16'd0);
      csr_write(ihex_pkg::CSR_TOTAL_LENGTH, 16'd0);
      queue_byte(8'hFF);
      wait_idle();

      // write to a missing register is a no-op
      csr_write(CSR_UNUSED, 16'hFFFF);

      // 3+2 split with the address wrapping past FFFF
      csr_write(ihex_pkg::CSR_RECORD_LENGTH, 16'd3);
      csr_write(ihex_pkg::CSR_TOTAL_LENGTH, 16'd5);
      csr_write(ihex_pkg::CSR_START_ADDRESS, 16'hFFFE);
      queue_byte(8'hA5);
      queue_byte(8'h5A);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(8'h80);
      wait_idle();

      // register writes between records of an open transfer: new record
      // length and address apply to the next record, total length only
      // to the next transfer
      csr_write(ihex_pkg::CSR_RECORD_LENGTH, 16'd2);
      csr_write(ihex_pkg::CSR_TOTAL_LENGTH, 16'd4);
      csr_write(ihex_pkg::CSR_START_ADDRESS, 16'h1234);
      queue_byte(8'h01);
      queue_byte(8'hFE);
      wait_idle();
      csr_write(ihex_pkg::CSR_RECORD_LENGTH, 16'd1);
      csr_write(ihex_pkg::CSR_TOTAL_LENGTH, 16'd7);
      csr_write(ihex_pkg::CSR_START_ADDRESS, 16'h8000);
      queue_byte(8'h7F);
      queue_byte(8'h10);
      wait_idle();

      // new start address and record length inside an open record: the
      // record keeps its header address, the next one starts at 4000
      csr_write(ihex_pkg::CSR_RECORD_LENGTH, 16'd4);
      csr_write(ihex_pkg::CSR_TOTAL_LENGTH, 16'd6);
      queue_byte(8'hC3);
      wait_idle();
      csr_write(ihex_pkg::CSR_START_ADDRESS, 16'h4000);
      csr_write(ihex_pkg::CSR_RECORD_LENGTH, 16'd255);
      csr_write(ihex_pkg::CSR_TOTAL_LENGTH, 16'd2);
      queue_random_bytes(5);
      wait_idle();

      // --- random part: three idling mixes ---
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 10; rsp_stall_pct = 80; end
            1: begin send_idle_pct = 80; rsp_stall_pct = 10; end
            default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            wait_idle();
            if ($urandom_range(3) == 0) begin
               csr_write(CSR_UNUSED, 16'($urandom_range(16'hFFFF)));
            end
            case ($urandom_range(9))
               0:       rl = 8'd0;
               1:       rl = 8'd255;
               default: rl = 8'($urandom_range(1, 8));
            endcase
            csr_write(ihex_pkg::CSR_RECORD_LENGTH, 16'(rl));
            tl = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 24));
            csr_write(ihex_pkg::CSR_TOTAL_LENGTH, tl);
            case ($urandom_range(3))
               0: csr_write(ihex_pkg::CSR_START_ADDRESS,
                            16'hFFF0 + 16'($urandom_range(15)));
               1: csr_write(ihex_pkg::CSR_START_ADDRESS, 16'($urandom_range(16'hFFFF)));
               default: ;   // address carries over
            endcase
            n = (tl == 16'd0) ? 1 : int'(tl);
            // sometimes stop short so the next settings land mid-transfer
            if ($urandom_range(4) == 0) n = $urandom_range(1, n);
            queue_random_bytes(n);
            phase_items += n;
         end
      end

      // --- widest settings: 255-byte records in a 65535-byte transfer ---
      // left open at the end; only the start of the first record is exercised
      wait_idle();
      csr_write(ihex_pkg::CSR_RECORD_LENGTH, 16'd255);
      csr_write(ihex_pkg::CSR_TOTAL_LENGTH, 16'hFFFF);
      csr_write(ihex_pkg::CSR_START_ADDRESS, 16'hFF80);
      queue_random_bytes(WIDE_XFER_LEN);
      wait_idle();

      // let anything stray come out before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (hex_text_q.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected characters never arrived", $time, hex_text_q.size());
      end

      $display("Covered %0d data bytes -> %0d characters, %0d lines, %0d end-of-file records,",
               bytes_accepted, chars_checked, records_closed, transfers_closed);
      $display("over zero/max record and transfer lengths, address wrap and mid-transfer writes.");
      if (fail_count == 0) begin
         $display("** intel_hex_record_encoder: PASSED **");
      end else begin
         $display("** intel_hex_record_encoder: FAILED **");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin : watchdog
      #4_000_000;
      $display("Timeout: %0d requests pending, %0d characters owed",
               bytes_queued - bytes_accepted, hex_text_q.size());
      $display("** intel_hex_record_encoder: FAILED **");
      $finish;
   end

endmodule
